FILE: rtl/core/rgbf_pkg.sv
package rgbf_pkg;

  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_TWEAK      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HASH_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRIES    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WORDS      = 2'd3;

  localparam logic [31:0] SEED_STEP = 32'hFBA4C795;
  localparam logic [31:0] C1 = 32'hcc9e2d51;
  localparam logic [31:0] C2 = 32'h1b873593;
  localparam logic [31:0] HADD = 32'he6546b64;
  localparam logic [31:0] F1 = 32'h85ebca6b;
  localparam logic [31:0] F2 = 32'hc2b2ae35;
  localparam logic [5:0] PROBE_LIMIT = 6'd50;
  localparam logic [1:0] GEN_FIRST = 2'd1;
  localparam logic [1:0] GEN_LAST  = 2'd3;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
    rotl = (x << r) | (x >> (32 - r));
  endfunction

endpackage

FILE: rtl/core/rolling_generational_bloom_filter.sv
// Channel | dir | tdata (low bit first)           | tuser
// s_axis  | in  | key_byte[7:0]                   | op[1:0], key_last in tlast
// m_axis  | out | found[0], status[1], zero pad   | -
// cfg     | in  | write enable, index, 32-bit data | -
// A key byte is taken each cycle while idle with no word waiting on m_axis.
// A finished key runs per probe a start step, a read and multiply pass per full
// 4-byte block, a tail pass (a single step if there is no tail), the final mix and
// the word pair read-modify-write (one shared multiplier), then the word is posted.
// Aging and the clear op sweep the filter memory one pair at a time, read then write;
// after rst a clearing pass of MAX_WORDS/2 pairs runs before input is taken.
// One key is worked at a time; the result register frees when m_axis takes it.
module rolling_generational_bloom_filter #(
  parameter int MAX_WORDS     = 1024,
  parameter int MAX_KEY_BYTES = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // key_byte
  input  logic [rgbf_pkg::OP_W-1:0] s_axis_tuser,  // op
  input  logic s_axis_tlast,          // key_last
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [7:0] m_axis_tdata,   // found, status, zeros
  input  logic cfg_we,
  input  logic [rgbf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rgbf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rgbf_pkg::*;

  localparam int AW  = $clog2(MAX_WORDS);
  localparam int PW  = (AW > 1) ? AW - 1 : 1;
  localparam int KW  = $clog2(MAX_KEY_BYTES);
  localparam int LW  = $clog2(MAX_KEY_BYTES + 1);
  localparam int WCW = AW + 1;
  localparam int BLW = LW - 1;
  localparam logic [PW-1:0] PAIR_MAX = PW'((MAX_WORDS / 2) - 1);

  typedef enum logic [4:0] {
    S_SWEEP_RD, S_SWEEP_WR, S_IDLE, S_START, S_BLK_RD, S_BLK_M1, S_BLK_M2, S_BLK_M3,
    S_BLK_MIX, S_TAIL, S_TAIL_M1, S_TAIL_M2, S_TAIL_M3, S_FIN_M1, S_FIN_M2, S_FIN_M3,
    S_FIN_END, S_PROBE, S_PRB_RD, S_PRB_WR, S_NEXT, S_DONE
  } state_t;

  // configuration
  logic [31:0] tweak;
  logic [5:0]  hash_count;
  logic [23:0] entries_per_gen;
  logic [10:0] words_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      tweak <= '0;
      hash_count <= 6'd1;
      entries_per_gen <= 24'd1;
      words_in_use <= 11'd1024;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TWEAK:      tweak <= cfg_data;
        REG_HASH_COUNT: hash_count <= cfg_data[5:0];
        REG_ENTRIES:    entries_per_gen <= cfg_data[23:0];
        REG_WORDS:      words_in_use <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // effective word count, even, clamped
  logic [WCW-1:0] eff_words;
  always_comb begin
    priority if (words_in_use < 11'd2) eff_words = WCW'(2);
    else if ({21'd0, words_in_use} > 32'(MAX_WORDS)) eff_words = WCW'(MAX_WORDS);
    else eff_words = WCW'(words_in_use);
    eff_words[0] = 1'b0;
  end
  logic [5:0] eff_probes;
  assign eff_probes = (hash_count > PROBE_LIMIT) ? PROBE_LIMIT : hash_count;
  logic [PW-1:0] last_pair;
  assign last_pair = PW'((eff_words >> 1) - WCW'(1));

  // memories: key buffer and filter pairs (generation bit 0 in lo, bit 1 in hi)
  logic [7:0]   key_mem [MAX_KEY_BYTES];
  logic [127:0] filt_mem [MAX_WORDS/2];
  logic [KW-1:0] key_raddr;
  logic [7:0]    key_rdata;
  logic [PW-1:0] f_addr;
  logic          f_we;
  logic [127:0]  f_wdata, f_rdata;

  state_t state;
  logic [LW-1:0] key_len;
  logic          key_ovf;
  logic [1:0]    gen;
  logic [23:0]   ent_cnt;
  logic [1:0]    op_l;
  logic [5:0]    probe;
  logic [BLW-1:0] blk;
  logic [1:0]    bsub;
  logic [31:0]   kw, h, mul_a, mul_b, mul_p;
  logic [PW-1:0] sweep_pair;
  logic          sweep_all, aging, found_r;
  logic [5:0]    bitpos;
  logic [PW-1:0] pair_r;
  logic [7:0]    out_data;
  logic          out_valid;

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (s_acc && s_axis_tuser != OP_CLEAR && s_axis_tuser != OP_NONE
        && {1'b0, key_len} < (LW+1)'(MAX_KEY_BYTES))
      key_mem[KW'(key_len)] <= s_axis_tdata;
    key_rdata <= key_mem[key_raddr];
  end

  always_ff @(posedge clk) begin
    if (f_we) filt_mem[f_addr] <= f_wdata;
    f_rdata <= filt_mem[f_addr];
  end

  // shared multiplier, registered product
  always_ff @(posedge clk) mul_p <= mul_a * mul_b;

  logic [LW-1:0] nblk;
  assign nblk = key_len >> 2;
  logic [63:0] range_p;
  assign range_p = {32'd0, h} * {{(64-WCW){1'b0}}, eff_words};
  logic [1:0] gen_next;
  assign gen_next = (gen == GEN_LAST) ? GEN_FIRST : gen + 2'd1;
  logic [63:0] lo_m, hi_m, keep, bitm;
  assign lo_m = {64{gen[0]}};
  assign hi_m = {64{gen[1]}};
  assign keep = (f_rdata[63:0] ^ lo_m) | (f_rdata[127:64] ^ hi_m);
  assign bitm = 64'd1 << bitpos;

  always_comb begin
    key_raddr = KW'({blk, bsub});
    f_we = 1'b0;
    f_addr = (state == S_SWEEP_RD || state == S_SWEEP_WR) ? sweep_pair : pair_r;
    f_wdata = '0;
    mul_a = kw;
    mul_b = C1;
    unique case (state)
      S_SWEEP_WR: begin
        f_we = 1'b1;
        f_wdata = sweep_all ? '0 : {f_rdata[127:64] & keep, f_rdata[63:0] & keep};
      end
      S_PRB_WR: begin
        f_we = (op_l == OP_INSERT);
        f_wdata = {(f_rdata[127:64] & ~bitm) | (gen[1] ? bitm : 64'd0),
                   (f_rdata[63:0] & ~bitm) | (gen[0] ? bitm : 64'd0)};
      end
      S_BLK_M3, S_TAIL_M2: begin mul_a = rotl(mul_p, 15); mul_b = C2; end
      S_FIN_M1: begin mul_a = h; mul_b = F1; end
      S_FIN_M2: begin mul_a = mul_p ^ (mul_p >> 13); mul_b = F2; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP_RD;
      sweep_pair <= '0;
      sweep_all <= 1'b1;
      aging <= 1'b0;
      key_len <= '0;
      key_ovf <= 1'b0;
      gen <= GEN_FIRST;
      ent_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && m_axis_tready) out_valid <= 1'b0;
      unique case (state)
        S_SWEEP_RD: state <= S_SWEEP_WR;
        S_SWEEP_WR: begin
          if (sweep_pair == (sweep_all ? PAIR_MAX : last_pair)) begin
            sweep_pair <= '0;
            state <= aging ? S_START : S_IDLE;
            aging <= 1'b0;
          end else begin
            sweep_pair <= sweep_pair + PW'(1);
            state <= S_SWEEP_RD;
          end
        end
        S_IDLE: if (s_acc) begin
          priority if (s_axis_tuser == OP_NONE) begin
          end else if (s_axis_tuser == OP_CLEAR) begin
            key_len <= '0; key_ovf <= 1'b0; gen <= GEN_FIRST; ent_cnt <= '0;
            out_data <= 8'd0; out_valid <= 1'b1;
            sweep_all <= 1'b1; sweep_pair <= '0; state <= S_SWEEP_RD;
          end else begin
            logic [LW-1:0] nl;
            nl = key_len;
            if ({1'b0, key_len} < (LW+1)'(MAX_KEY_BYTES)) nl = key_len + LW'(1);
            else key_ovf <= 1'b1;
            key_len <= nl;
            if (s_axis_tlast) begin
              op_l <= s_axis_tuser;
              probe <= '0;
              found_r <= 1'b1;
              if (key_ovf || {1'b0, key_len} >= (LW+1)'(MAX_KEY_BYTES)) begin
                out_data <= 8'd2; out_valid <= 1'b1;
                key_len <= '0; key_ovf <= 1'b0;
              end else if (s_axis_tuser == OP_INSERT && ent_cnt >= entries_per_gen) begin
                ent_cnt <= 24'd1; gen <= gen_next;
                aging <= 1'b1; sweep_all <= 1'b0; sweep_pair <= '0;
                state <= S_SWEEP_RD;
              end else begin
                if (s_axis_tuser == OP_INSERT) ent_cnt <= ent_cnt + 24'd1;
                state <= S_START;
              end
            end
          end
        end
        // one probe: murmur over the buffered key
        S_START: begin
          if (probe == eff_probes) begin
            out_data <= {6'd0, 1'b0, (op_l == OP_QUERY) && found_r};
            out_valid <= 1'b1; key_len <= '0; state <= S_IDLE;
          end else begin
            h <= 32'(probe) * SEED_STEP + tweak;
            blk <= '0; bsub <= '0; kw <= '0;
            state <= (nblk != '0) ? S_BLK_RD : S_TAIL;
          end
        end
        S_BLK_RD: begin
          // read 4 bytes, one per cycle
          bsub <= bsub + 2'd1;
          if (bsub != 2'd0) kw <= {key_rdata, kw[31:8]};
          if (bsub == 2'd3) state <= S_BLK_M1;
        end
        S_BLK_M1: begin kw <= {key_rdata, kw[31:8]}; state <= S_BLK_M2; end
        S_BLK_M2: state <= S_BLK_M3;
        S_BLK_M3: state <= S_BLK_MIX;
        S_BLK_MIX: begin
          h <= rotl(h ^ mul_p, 13) * 32'd5 + HADD;
          blk <= blk + BLW'(1); bsub <= '0; kw <= '0;
          state <= (LW'(blk) + LW'(1) < nblk) ? S_BLK_RD : S_TAIL;
        end
        S_TAIL: begin
          // bytes of the tail, one per cycle, then a final step for the read latency
          if (bsub != 2'd0) kw <= kw | (32'(key_rdata) << (8 * (int'(bsub) - 1)));
          if (bsub == key_len[1:0]) begin
            state <= (key_len[1:0] != 2'd0) ? S_TAIL_M1 : S_FIN_END;
            if (key_len[1:0] == 2'd0) h <= h ^ 32'(key_len);
          end
          bsub <= bsub + 2'd1;
        end
        S_TAIL_M1: state <= S_TAIL_M2;
        S_TAIL_M2: state <= S_TAIL_M3;
        S_TAIL_M3: begin h <= h ^ mul_p ^ 32'(key_len); state <= S_FIN_END; end
        S_FIN_END: begin h <= h ^ (h >> 16); state <= S_FIN_M1; end
        S_FIN_M1: state <= S_FIN_M2;
        S_FIN_M2: state <= S_FIN_M3;
        S_FIN_M3: begin
          h <= mul_p ^ (mul_p >> 16);
          state <= S_PROBE;
        end
        S_PROBE: begin
          bitpos <= h[5:0];
          pair_r <= PW'(range_p[63:33]);
          state <= S_PRB_RD;
        end
        S_PRB_RD: state <= S_PRB_WR;
        S_PRB_WR: begin
          if (((f_rdata[63:0] | f_rdata[127:64]) & bitm) == 64'd0) found_r <= 1'b0;
          state <= S_NEXT;
        end
        S_NEXT: begin
          probe <= probe + 6'd1;
          state <= (op_l == OP_QUERY && !found_r) ? S_DONE : S_START;
        end
        S_DONE: begin
          out_data <= 8'd0; out_valid <= 1'b1; key_len <= '0; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = out_data;

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> (state == S_IDLE)) else $error("ready outside idle");
  a_gen_nz: assert property (@(posedge clk) disable iff (rst)
    gen != 2'd0) else $error("generation code zero");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");
endmodule
